>>> rtl/ptli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptli_pkg
// shared types and constants for the profile table interpolator
// ----------------------------------------------------------------------------
package ptli_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_NUM_TABLES = 5;

    localparam int HEIGHT_W = 32;
    localparam int VALUE_W  = 64;
    localparam int SPEC_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_RANGE    = 3'd2,
        ST_SPECIES  = 3'd3,
        ST_BAD_LOAD = 3'd4
    } status_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // control from sequencer to divider
    typedef struct packed {
        logic        go;
        logic [33:0] num;
        logic [33:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [49:0] quo;
    } div_rsp_t;

endpackage

>>> rtl/ptli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptli_div
// restoring divider, one quotient bit per cycle, unsigned num<<16 / den
// ----------------------------------------------------------------------------
module ptli_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ptli_pkg::div_req_t req,
    output ptli_pkg::div_rsp_t rsp
);
    import ptli_pkg::*;

    localparam int QW = 50;

    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [34:0]   rem_reg, rem_next;
    logic [33:0]   den_reg, den_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [34:0]   trial;
    logic [35:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[33:0], dvd_reg[QW-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.go)
        begin
            dvd_next  = {req.num, 16'd0};
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (!diff[35])
            begin
                rem_next = diff[34:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/ptli_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptli_store
// height and value memories, one write and one registered read port
// ----------------------------------------------------------------------------
module ptli_store #(
    parameter int DEPTH = ptli_pkg::DEF_MAX_POINTS * ptli_pkg::DEF_NUM_TABLES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [ptli_pkg::HEIGHT_W-1:0] wr_height,
    input  logic [ptli_pkg::VALUE_W-1:0]  wr_value,
    input  logic [AW-1:0]                 rd_addr,
    output logic [ptli_pkg::HEIGHT_W-1:0] rd_height,
    output logic [ptli_pkg::VALUE_W-1:0]  rd_value
);
    import ptli_pkg::*;

    logic [HEIGHT_W-1:0] height_mem [DEPTH];
    logic [VALUE_W-1:0]  value_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            height_mem[wr_addr] <= wr_height;
            value_mem[wr_addr]  <= wr_value;
        end
        rd_height <= height_mem[rd_addr];
        rd_value  <= value_mem[rd_addr];
    end

endmodule

>>> rtl/profile_table_linear_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_table_linear_interp
// piecewise linear interpolation over per-species profile tables
// ----------------------------------------------------------------------------
// channel  | signals                                          | handshake
// command  | cmd species altitude point_value point_index     | start & !busy
//          | last_point                                       |
// result   | value status                                     | done strobe
// config   | missing_value_wr missing_value_data              | write enable
//
// a load, an unsupported species or a table under two points: strobe the cycle after accept
// a query binary-searches, a probe and a compare state per probe, up to 9 probes
// for 256 points, then reads both segment ends and checks the segment; a failed check
// strobes via S_OUT, a full query via the divider, the mac steps, S_SUM and S_OUT
// start is taken again in the strobe cycle; reset clears control state, counts and missing_value only
// results are strobed for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module profile_table_linear_interp #(
    parameter int MAX_POINTS = ptli_pkg::DEF_MAX_POINTS,
    parameter int NUM_TABLES = ptli_pkg::DEF_NUM_TABLES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [ptli_pkg::SPEC_W-1:0]   species,
    input  logic [ptli_pkg::HEIGHT_W-1:0] altitude,
    input  logic [ptli_pkg::VALUE_W-1:0]  point_value,
    input  logic [ptli_pkg::INDEX_W-1:0]  point_index,
    input  logic                          last_point,
    input  logic                          missing_value_wr,
    input  logic [ptli_pkg::VALUE_W-1:0]  missing_value_data,
    output logic                          done,
    output logic [ptli_pkg::VALUE_W-1:0]  value,
    output logic [ptli_pkg::STATUS_W-1:0] status
);
    import ptli_pkg::*;

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int DEPTH = MAX_POINTS * NUM_TABLES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PROBE = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_RD1   = 10'b0000001000,
        S_RD2   = 10'b0000010000,
        S_CHECK = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_SUM   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] counts_reg [NUM_TABLES];
    logic [VALUE_W-1:0] missing_reg;
    logic [TW-1:0] sp_reg;
    logic signed [HEIGHT_W-1:0] alt_reg;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, n_reg;
    logic signed [HEIGHT_W-1:0] h1_reg;
    logic [VALUE_W-1:0] v1_reg, v2_reg;
    logic signed [33:0] num_reg;
    logic signed [49:0] fq_reg;
    logic signed [127:0] acc_reg;
    logic [VALUE_W-1:0] res_reg;
    status_t st_reg;
    logic done_reg;
    logic [1:0] step_reg;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr, rd_addr_reg;
    logic [HEIGHT_W-1:0] rd_height;
    logic [VALUE_W-1:0] rd_value;
    logic [CW-1:0] mid, seg;
    div_req_t dreq;
    div_rsp_t drsp;
    logic accept;
    logic sp_ok;
    logic [CW-1:0] pidx;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign sp_ok  = (32'(species) < 32'(NUM_TABLES));
    assign pidx   = CW'(point_index);
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign wr_en   = accept && (cmd == CMD_LOAD) && sp_ok
                     && (32'(point_index) < 32'(MAX_POINTS));
    assign wr_addr = AW'(32'(species) * 32'(MAX_POINTS) + 32'(point_index));

    always_comb
    begin
        seg = lo_reg;
        if (lo_reg == '0)
            seg = CW'(1);
        else if (lo_reg == n_reg)
            seg = n_reg - CW'(1);
    end

    ptli_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_height(altitude),
        .wr_value (point_value),
        .rd_addr  (rd_addr),
        .rd_height(rd_height),
        .rd_value (rd_value)
    );

    ptli_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    // signed range test on 38-bit products and sign fix of the 34-bit numerator/denominator
    logic signed [37:0] t5n, t3d, t8d;
    logic [33:0] abs_num;
    logic signed [33:0] dd;
    logic signed [33:0] nn;
    logic signed [33:0] sn, sd;
    assign dd = 34'(signed'(rd_height)) - 34'(h1_reg);
    assign nn = 34'(alt_reg) - 34'(h1_reg);
    assign sn = dd[33] ? -nn : nn;
    assign sd = dd[33] ? -dd : dd;

    // one 33x18 partial product per mac cycle
    logic signed [17:0] w1;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] prod;
    logic signed [127:0] addend;
    logic signed [127:0] sum, rnd;
    assign prod   = mul_a * mul_b;
    assign addend = step_reg[0] ? (128'(prod) <<< 32) : 128'(prod);
    assign sum    = acc_reg + 128'sd32768;
    assign rnd    = sum >>> 16;

    always_comb
    begin
        w1 = 18'sd65536 - 18'(fq_reg);
        unique case (step_reg)
            2'd0:
            begin
                mul_a = {1'b0, v1_reg[31:0]};
                mul_b = w1;
            end
            2'd1:
            begin
                mul_a = {v1_reg[63], v1_reg[63:32]};
                mul_b = w1;
            end
            2'd2:
            begin
                mul_a = {1'b0, v2_reg[31:0]};
                mul_b = 18'(fq_reg);
            end
            2'd3:
            begin
                mul_a = {v2_reg[63], v2_reg[63:32]};
                mul_b = 18'(fq_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        rd_addr    = rd_addr_reg;
        abs_num    = sn[33] ? 34'(-sn) : 34'(sn);
        dreq.go    = 1'b0;
        dreq.num   = abs_num;
        dreq.den   = 34'(sd);
        t5n        = 38'(sn) * 38'sd5;
        t3d        = -(38'(sd) * 38'sd3);
        t8d        = 38'(sd) * 38'sd8;
        unique case (state_reg)
            S_IDLE:  ;
            S_PROBE:
            begin
                rd_addr = AW'(32'(sp_reg) * 32'(MAX_POINTS) + 32'(mid));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (signed'(rd_height) > alt_reg)
                    hi_next = mid;
                else
                    lo_next = mid + CW'(1);
                if (lo_next < hi_next)
                    state_next = S_PROBE;
                else
                    state_next = S_RD1;
            end
            S_RD1:
            begin
                rd_addr = AW'(32'(sp_reg) * 32'(MAX_POINTS) + 32'(seg) - 32'd1);
                state_next = S_RD2;
            end
            S_RD2:
            begin
                rd_addr = AW'(32'(sp_reg) * 32'(MAX_POINTS) + 32'(seg));
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sd == '0)
                    state_next = S_OUT;
                else if (!(t5n > t3d && t5n < t8d))
                    state_next = S_OUT;
                else
                begin
                    dreq.go    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
                if (drsp.done)
                    state_next = S_MUL;
            S_MUL:
                if (step_reg == 2'd3)
                    state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            missing_reg <= '0;
            for (int t = 0; t < NUM_TABLES; t++)
                counts_reg[t] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (missing_value_wr)
                missing_reg <= missing_value_data;
            if (accept)
            begin
                if (cmd == CMD_LOAD)
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (wr_en)
                    begin
                        if (last_point)
                            counts_reg[TW'(species)] <= pidx + CW'(1);
                        else if (point_index == '0)
                            counts_reg[TW'(species)] <= '0;
                    end
                end
                else if (!sp_ok)
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                else if (counts_reg[TW'(species)] < CW'(2))
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                else
                    state_reg <= S_PROBE;
            end
            if (state_reg == S_OUT)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        rd_addr_reg <= rd_addr;
        if (accept)
        begin
            res_reg <= '0;
            alt_reg <= signed'(altitude);
            sp_reg  <= TW'(species);
            lo_reg  <= '0;
            hi_reg  <= counts_reg[TW'(species)];
            n_reg   <= counts_reg[TW'(species)];
            if (cmd == CMD_LOAD)
                st_reg <= wr_en ? ST_OK : ST_BAD_LOAD;
            else if (!sp_ok)
            begin
                st_reg  <= ST_SPECIES;
                res_reg <= missing_reg;
            end
            else if (counts_reg[TW'(species)] < CW'(2))
                st_reg <= ST_FEW;
            else
                st_reg <= ST_RANGE;
        end
        if (state_reg == S_RD2)
        begin
            h1_reg <= signed'(rd_height);
            v1_reg <= rd_value;
        end
        if (state_reg == S_CHECK)
        begin
            v2_reg   <= rd_value;
            num_reg  <= sn;
            acc_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == S_DIV && drsp.done)
            fq_reg <= num_reg[33] ? -signed'(drsp.quo) : signed'(drsp.quo);
        if (state_reg == S_MUL)
        begin
            acc_reg  <= acc_reg + addend;
            step_reg <= step_reg + 2'd1;
        end
        if (state_reg == S_SUM)
        begin
            st_reg <= ST_OK;
            if (rnd > 128'sh7FFFFFFFFFFFFFFF)
                res_reg <= 64'h7FFFFFFFFFFFFFFF;
            else if (rnd < -128'sh8000000000000000)
                res_reg <= 64'h8000000000000000;
            else
                res_reg <= rnd[63:0];
        end
    end

    assign done   = done_reg;
    assign value  = res_reg;
    assign status = st_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result strobe while working");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !done || $past(state_reg) == S_OUT)
        else $error("strobe without finishing");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && drsp.done |=> state_reg == S_MUL)
        else $error("quotient not followed by multiply");

endmodule

>>> dv/profile_table_linear_interp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_table_linear_interp_tb
// self-checking bench for the profile table interpolator: loads tables of
// points, queries them at random altitudes and compares every result beat
// against an in-bench interpolation predictor, under several idle patterns
// ----------------------------------------------------------------------------
module profile_table_linear_interp_tb;
    import ptli_pkg::*;

    localparam int  NTAB  = DEF_NUM_TABLES;
    localparam int  NPTS  = DEF_MAX_POINTS;
    localparam int  LIMIT = 1000000;
    localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VMIN = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } interp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_LOAD;
    logic [2:0]  species = '0;
    logic [31:0] altitude = '0;
    logic [63:0] point_value = '0;
    logic [7:0]  point_index = '0;
    logic        last_point = 1'b0;
    logic        missing_value_wr = 1'b0;
    logic [63:0] missing_value_data = '0;
    logic        done;
    logic [63:0] value;
    logic [2:0]  status;

    longint         tbl_h [NTAB][NPTS];
    logic [63:0]    tbl_v [NTAB][NPTS];
    bit             tbl_w [NTAB][NPTS];
    int             tbl_n [NTAB];
    logic [63:0]    missing_shadow = '0;
    interp_result_t pending_results [$];
    int             errors = 0;
    int             cycles = 0;
    int             items_sent = 0;
    int             idle_pct = 0;

    profile_table_linear_interp dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .species            (species),
        .altitude           (altitude),
        .point_value        (point_value),
        .point_index        (point_index),
        .last_point         (last_point),
        .missing_value_wr   (missing_value_wr),
        .missing_value_data (missing_value_data),
        .done               (done),
        .value              (value),
        .status             (status)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        interp_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected beat value=%h status=%0d", value, status));
            else
            begin
                exp_r = pending_results.pop_front();
                if (value !== exp_r.value)
                    report($sformatf("value %h, want %h", value, exp_r.value));
                if (status !== exp_r.status)
                    report($sformatf("status %0d, want %0d", status, exp_r.status));
            end
        end
    end

    // interpolation predictor, updates table shadow on loads
    task automatic interp_predict(input logic c, input logic [2:0] sp, input logic [31:0] alt,
                                  input logic [63:0] pv, input logic [7:0] idx,
                                  input logic lst);
        interp_result_t   r;
        int               n, lo, hi, mid, i;
        longint           a, h1, h2, num, d, fq;
        logic signed [129:0] w1, w2, acc;
        r.value  = '0;
        r.status = ST_OK;
        a = longint'($signed(alt));
        if (c == CMD_LOAD)
        begin
            if (sp >= NTAB)
                r.status = ST_BAD_LOAD;
            else
            begin
                if (idx == 0)
                    tbl_n[sp] = 0;
                tbl_h[sp][idx] = a;
                tbl_v[sp][idx] = pv;
                tbl_w[sp][idx] = 1'b1;
                if (lst)
                    tbl_n[sp] = int'(idx) + 1;
            end
        end
        else if (sp >= NTAB)
        begin
            r.value  = missing_shadow;
            r.status = ST_SPECIES;
        end
        else if (tbl_n[sp] < 2)
            r.status = ST_FEW;
        else
        begin
            n  = tbl_n[sp];
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tbl_h[sp][mid] > a)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            i = (lo == 0) ? 1 : (lo == n) ? n - 1 : lo;
            h1 = tbl_h[sp][i-1];
            h2 = tbl_h[sp][i];
            num = a - h1;
            d = h2 - h1;
            if (d < 0)
            begin
                d = -d;
                num = -num;
            end
            if (d == 0 || !(5 * num > -3 * d && 5 * num < 8 * d))
                r.status = ST_RANGE;
            else
            begin
                fq  = (num * 65536) / d;
                w1  = $signed(tbl_v[sp][i-1]);
                w2  = $signed(tbl_v[sp][i]);
                acc = w1 * (65536 - fq) + w2 * fq + 32768;
                acc = acc >>> 16;
                if (acc[129:63] == '0 || acc[129:63] == '1)
                    r.value = acc[63:0];
                else
                    r.value = acc[129] ? VMIN : VMAX;
            end
        end
        pending_results.push_back(r);
    endtask

    task automatic send_item(input logic c, input logic [2:0] sp, input logic [31:0] alt,
                             input logic [63:0] pv, input logic [7:0] idx, input logic lst);
        start       <= 1'b1;
        cmd         <= c;
        species     <= sp;
        altitude    <= alt;
        point_value <= pv;
        point_index <= idx;
        last_point  <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        interp_predict(c, sp, alt, pv, idx, lst);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_missing(input logic [63:0] v);
        drain();
        missing_value_wr   <= 1'b1;
        missing_value_data <= v;
        @(posedge clk);
        missing_value_wr <= 1'b0;
        missing_shadow = v;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return VMAX;
            2: return VMIN;
            3: return 64'($signed($urandom_range(0, 2000)) - 1000);
            default: return {$urandom, $urandom} >>> $urandom_range(0, 60);
        endcase
    endfunction

    function automatic bit table_readable(input int sp);
        for (int k = 0; k < tbl_n[sp]; k++)
            if (!tbl_w[sp][k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic load_table(input int sp, input int n);
        int   h;
        int   step;
        h = $signed($urandom) >>> $urandom_range(0, 6);
        for (int k = 0; k < n; k++)
        begin
            send_item(CMD_LOAD, 3'(sp), 32'(h), rand_value(), 8'(k), k == n - 1);
            case ($urandom_range(0, 19))
                0: step = 0;
                1: step = -$urandom_range(1, 5000);
                default: step = $urandom_range(1, 1 << $urandom_range(0, 27));
            endcase
            h = h + step;
        end
    endtask

    task automatic query_table(input int sp, input int count);
        int     k;
        longint a;
        for (int q = 0; q < count; q++)
        begin
            if (!table_readable(sp))
                return;
            if (tbl_n[sp] == 0 || $urandom_range(0, 9) == 0)
                a = longint'($signed($urandom));
            else
            begin
                k = $urandom_range(0, tbl_n[sp] - 1);
                a = tbl_h[sp][k];
                if ($urandom_range(0, 4) != 0)
                    a = a + longint'($signed($urandom) >>> $urandom_range(0, 31));
            end
            send_item(CMD_QUERY, 3'(sp), 32'(a), rand_value(), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_directed();
        set_missing(VMIN);
        send_item(CMD_QUERY, 3'd0, 32'h8000_0000, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd5, 32'h7FFF_FFFF, '0, '0, 1'b0);
        send_item(CMD_LOAD, 3'd7, 32'd10, VMAX, 8'd3, 1'b1);
        send_item(CMD_LOAD, 3'd1, 32'd1000, VMAX, 8'd0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd1000, '0, '0, 1'b0);
        send_item(CMD_LOAD, 3'd1, 32'd2000, VMIN, 8'd1, 1'b1);
        send_item(CMD_QUERY, 3'd1, 32'd1500, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd500, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd2500, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd399, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd2601, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd1, 32'd400, '0, '0, 1'b0);
        send_item(CMD_LOAD, 3'd2, 32'd5000, 64'd100, 8'd0, 1'b0);
        send_item(CMD_LOAD, 3'd2, 32'd5000, 64'd200, 8'd1, 1'b1);
        send_item(CMD_QUERY, 3'd2, 32'd5000, '0, '0, 1'b0);
        send_item(CMD_LOAD, 3'd3, 32'h7FFF_FFFF, VMIN, 8'd0, 1'b0);
        send_item(CMD_LOAD, 3'd3, 32'h8000_0000, VMAX, 8'd1, 1'b1);
        send_item(CMD_QUERY, 3'd3, 32'd0, '0, '0, 1'b0);
        send_item(CMD_QUERY, 3'd3, 32'h8000_0000, '0, '0, 1'b0);
        set_missing(VMAX);
        send_item(CMD_QUERY, 3'd6, 32'd0, '0, '0, 1'b0);
        set_missing('0);
        send_item(CMD_QUERY, 3'd7, 32'd0, '0, '0, 1'b0);
        send_item(CMD_LOAD, 3'd1, 32'd0, '0, 8'd0, 1'b1);
        send_item(CMD_QUERY, 3'd1, 32'd0, '0, '0, 1'b0);
    endtask

    task automatic test_full_table();
        idle_pct = 0;
        load_table(4, NPTS);
        query_table(4, 24);
    endtask

    task automatic test_random();
        int pct [4] = '{0, 54, 0, 25};
        int sp;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_missing({$urandom, $urandom});
            idle_pct = pct[ph];
            while (items_sent < 320 + 150 * (ph + 1))
            begin
                sp = $urandom_range(0, NTAB - 1);
                case ($urandom_range(0, 9))
                    0: send_item(CMD_LOAD, 3'($urandom_range(NTAB, 7)), $urandom,
                                 rand_value(), 8'($urandom), 1'($urandom));
                    1: send_item(CMD_QUERY, 3'($urandom_range(NTAB, 7)), $urandom,
                                 rand_value(), 8'($urandom), 1'($urandom));
                    2: send_item(CMD_LOAD, 3'(sp), $urandom, rand_value(),
                                 8'($urandom_range(0, 12)), 1'($urandom));
                    3: query_table(sp, $urandom_range(1, 4));
                    default:
                    begin
                        load_table(sp, ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8));
                        query_table(sp, $urandom_range(3, 8));
                    end
                endcase
                if (ph == 1 && items_sent % 50 == 0)
                    drain();
            end
        end
    endtask

    initial
    begin
        for (int t = 0; t < NTAB; t++)
            tbl_n[t] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        drain();
        repeat (120) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ptli_pkg.sv
rtl/ptli_div.sv
rtl/ptli_store.sv
rtl/profile_table_linear_interp.sv
dv/profile_table_linear_interp_tb.sv
